FILE: src/pciwm_pkg.sv
// Shared types, codes and the field compare for the PCI identity match table.
// No dependencies; every other file in src imports this package.
package pciwm_pkg;

    localparam logic [15:0] WILD16 = 16'hFFFF;
    localparam logic [7:0]  WILD8  = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        OP_REGISTER = 1'b0,
        OP_LOOKUP   = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    // Seven identity fields of a pattern or of a device.
    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] device_id;
        logic [7:0]  class_code;
        logic [7:0]  subclass_code;
        logic [7:0]  prog_interface;
        logic [15:0] subsystem_id;
        logic [15:0] subsystem_vendor;
    } key_t;

    // Lookup token handed from cell to cell.
    typedef struct packed {
        logic        active;
        logic        found;
        logic [15:0] handle;
        logic [3:0]  index;
        key_t        key;
    } link_t;

    // Only the pattern side acts as a wildcard.
    function automatic logic key_match(key_t pat, key_t dev);
        logic m;
        m = (pat.vendor_id == WILD16 || pat.vendor_id == dev.vendor_id)
         && (pat.device_id == WILD16 || pat.device_id == dev.device_id)
         && (pat.class_code == WILD8 || pat.class_code == dev.class_code)
         && (pat.subclass_code == WILD8 || pat.subclass_code == dev.subclass_code)
         && (pat.prog_interface == WILD8 || pat.prog_interface == dev.prog_interface)
         && (pat.subsystem_id == WILD16 || pat.subsystem_id == dev.subsystem_id)
         && (pat.subsystem_vendor == WILD16
             || pat.subsystem_vendor == dev.subsystem_vendor);
        return m;
    endfunction

endpackage

FILE: src/pciwm_cell.sv
// One table entry: stores a pattern and its handle, and passes the lookup
// token on to the next entry through a register. Depends on pciwm_pkg.
module pciwm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  pciwm_pkg::key_t   pattern_in,
    input  logic [15:0]       handle_in,
    input  logic              enabled,
    input  pciwm_pkg::link_t  link_in,
    output pciwm_pkg::link_t  link_out
);
    import pciwm_pkg::*;

    localparam logic [3:0] IDX = 4'(CELL_INDEX);

    key_t        pattern_reg;
    logic [15:0] handle_reg;
    link_t       link_reg;
    link_t       link_next;
    logic        hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pattern_reg <= pattern_in;
            handle_reg  <= handle_in;
        end
    end

    assign hit = link_in.active && !link_in.found && enabled
              && key_match(pattern_reg, link_in.key);

    always_comb
    begin
        link_next = link_in;
        if (hit)
        begin
            link_next.found  = 1'b1;
            link_next.handle = handle_reg;
            link_next.index  = IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

FILE: src/pci_id_wildcard_match_table.sv
// Top level of the PCI identity wildcard match table: control, entry count,
// result register and the row of pciwm_cell entries. Depends on pciwm_pkg.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | opcode, seven identity fields, handle_in
//  out     | out_valid/out_ready | status, handle_out, entry_index
//
// A register item gives its result in the cycle after its transfer.
// A lookup token walks the cell row one entry per cycle, through every cell
// register; the result register takes the outcome as the token leaves the
// last cell, and the result is then shown from the S_RESP state.
// One item is in the block at a time; in_ready is low from the input transfer
// until the result transfer. Reset empties the table and leaves no result.
module pci_id_wildcard_match_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] vendor_id,
    input  logic [15:0] device_id,
    input  logic [7:0]  class_code,
    input  logic [7:0]  subclass_code,
    input  logic [7:0]  prog_interface,
    input  logic [15:0] subsystem_id,
    input  logic [15:0] subsystem_vendor,
    input  logic [15:0] handle_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] handle_out,
    output logic [3:0]  entry_index
);
    import pciwm_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [1:0]        status_reg;
    logic [15:0]       handle_reg;
    logic [3:0]        index_reg;

    logic              in_xfer;
    logic              out_xfer;
    logic              is_full;
    logic              write_go;
    logic              scan_start;
    logic              scan_done;
    key_t              key_in;
    link_t             link [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] wr_en;
    logic [TABLE_DEPTH-1:0] enabled;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign is_full  = (count_reg == FULL_COUNT);

    assign key_in.vendor_id        = vendor_id;
    assign key_in.device_id        = device_id;
    assign key_in.class_code       = class_code;
    assign key_in.subclass_code    = subclass_code;
    assign key_in.prog_interface   = prog_interface;
    assign key_in.subsystem_id     = subsystem_id;
    assign key_in.subsystem_vendor = subsystem_vendor;

    // Head of the row: a fresh token that has not found anything yet.
    always_comb
    begin
        link[0].active = scan_start;
        link[0].found  = 1'b0;
        link[0].handle = 16'd0;
        link[0].index  = 4'd0;
        link[0].key    = key_in;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign wr_en[i]   = write_go && (count_reg == CW'(i));
        assign enabled[i] = (CW'(i) < count_reg);

        pciwm_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (wr_en[i]),
            .pattern_in (key_in),
            .handle_in  (handle_in),
            .enabled    (enabled[i]),
            .link_in    (link[i]),
            .link_out   (link[i+1])
        );
    end

    assign scan_done = link[TABLE_DEPTH].active;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (opcode == OP_LOOKUP) ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_xfer)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        write_go   = 1'b0;
        scan_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                write_go   = in_valid && (opcode == OP_REGISTER) && !is_full;
                scan_start = in_valid && (opcode == OP_LOOKUP);
            end
            S_SCAN:
            begin
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign count_next = write_go ? count_reg + CW'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && opcode == OP_REGISTER)
        begin
            status_reg <= is_full ? ST_FULL : ST_OK;
            handle_reg <= 16'd0;
            index_reg  <= is_full ? 4'd0 : 4'(count_reg);
        end
        else if (state_reg == S_SCAN && scan_done)
        begin
            status_reg <= link[TABLE_DEPTH].found ? ST_OK : ST_NOMATCH;
            handle_reg <= link[TABLE_DEPTH].found ? link[TABLE_DEPTH].handle : 16'd0;
            index_reg  <= link[TABLE_DEPTH].found ? link[TABLE_DEPTH].index : 4'd0;
        end
    end

    assign status      = status_reg;
    assign handle_out  = handle_reg;
    assign entry_index = index_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides open at once");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table depth");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> state_reg == S_SCAN)
        else $error("lookup token left the row outside a scan");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (handle_out == 16'd0 && entry_index == 4'd0))
        else $error("table full result carries a handle or index");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_RESP && status == ST_OK))
        else $error("entry count moved without a register result");

endmodule

FILE: tb/match_table_checker.sv
// Checker for the PCI identity wildcard match table: watches both channels,
// keeps its own copy of the pattern table and compares every result.
// Depends on pciwm_pkg for the key, opcode and status types.
module match_table_checker #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] vendor_id,
    input  logic [15:0] device_id,
    input  logic [7:0]  class_code,
    input  logic [7:0]  subclass_code,
    input  logic [7:0]  prog_interface,
    input  logic [15:0] subsystem_id,
    input  logic [15:0] subsystem_vendor,
    input  logic [15:0] handle_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [15:0] handle_out,
    input  logic [3:0]  entry_index,
    output int          pending,
    output int          failures
);
    import pciwm_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [15:0] handle;
        logic [3:0]  index;
    } match_result_t;

    key_t          table_keys [DEPTH];
    logic [15:0]   table_handles [DEPTH];
    int            table_used = 0;
    match_result_t expected_results [$];
    int            mismatch_count = 0;
    int            result_number = 0;

    assign failures = mismatch_count;

    function automatic logic field_hit16(logic [15:0] pat, logic [15:0] dev);
        return (pat == WILD16) || (pat == dev);
    endfunction

    function automatic logic field_hit8(logic [7:0] pat, logic [7:0] dev);
        return (pat == WILD8) || (pat == dev);
    endfunction

    // Applies one item to the table copy and returns the result it should give.
    function automatic match_result_t resolve_item(opcode_t op, key_t dev,
                                                   logic [15:0] handle);
        match_result_t r;
        key_t          p;
        r.status = ST_NOMATCH;
        r.handle = '0;
        r.index  = '0;
        if (op == OP_REGISTER) begin
            if (table_used >= DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                table_keys[table_used]    = dev;
                table_handles[table_used] = handle;
                r.status = ST_OK;
                r.index  = 4'(table_used);
                table_used++;
            end
            return r;
        end
        // The first entry in insertion order wins.
        for (int i = 0; i < table_used; i++) begin
            p = table_keys[i];
            if (field_hit16(p.vendor_id, dev.vendor_id)
                && field_hit16(p.device_id, dev.device_id)
                && field_hit8(p.class_code, dev.class_code)
                && field_hit8(p.subclass_code, dev.subclass_code)
                && field_hit8(p.prog_interface, dev.prog_interface)
                && field_hit16(p.subsystem_id, dev.subsystem_id)
                && field_hit16(p.subsystem_vendor, dev.subsystem_vendor))
            begin
                r.status = ST_OK;
                r.handle = table_handles[i];
                r.index  = 4'(i);
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("result %0d: %s is %0h, expected %0h", result_number, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        match_result_t want;
        match_result_t predicted;
        key_t          dev;
        if (!rst_n)
        begin
            table_used = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_number++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("status of a transfer with no item pending",
                                    {14'd0, status}, 16'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", {14'd0, status}, {14'd0, want.status});
                    if (handle_out !== want.handle)
                        report_mismatch("handle_out", handle_out, want.handle);
                    if (entry_index !== want.index)
                        report_mismatch("entry_index", {12'd0, entry_index},
                                        {12'd0, want.index});
                end
            end
            if (in_valid && in_ready)
            begin
                dev.vendor_id        = vendor_id;
                dev.device_id        = device_id;
                dev.class_code       = class_code;
                dev.subclass_code    = subclass_code;
                dev.prog_interface   = prog_interface;
                dev.subsystem_id     = subsystem_id;
                dev.subsystem_vendor = subsystem_vendor;
                predicted = resolve_item(opcode_t'(opcode), dev, handle_in);
                expected_results.insert(expected_results.size(), predicted);
            end
            pending <= expected_results.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Top of the match table testbench: clock, reset, directed and random items,
// output stalls, watchdog and verdict. Depends on pciwm_pkg,
// pci_id_wildcard_match_table and match_table_checker.
module tb;
    import pciwm_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic        opcode           = 1'b0;
    logic [15:0] vendor_id        = '0;
    logic [15:0] device_id        = '0;
    logic [7:0]  class_code       = '0;
    logic [7:0]  subclass_code    = '0;
    logic [7:0]  prog_interface   = '0;
    logic [15:0] subsystem_id     = '0;
    logic [15:0] subsystem_vendor = '0;
    logic [15:0] handle_in        = '0;
    logic        out_valid;
    logic        out_ready        = 1'b0;
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic [3:0]  entry_index;

    int   pending;
    int   failures;
    int   quiet_cycles   = 0;
    int   stall_left     = 0;
    logic sender_idles   = 1'b1;
    logic receiver_idles = 1'b1;
    logic drain_request  = 1'b0;

    // Patterns that went into the table, used to aim lookups at real entries.
    key_t sent_patterns [DEPTH];
    int   registered = 0;

    pci_id_wildcard_match_table #(.TABLE_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .vendor_id(vendor_id), .device_id(device_id),
        .class_code(class_code), .subclass_code(subclass_code),
        .prog_interface(prog_interface), .subsystem_id(subsystem_id),
        .subsystem_vendor(subsystem_vendor), .handle_in(handle_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .handle_out(handle_out), .entry_index(entry_index)
    );

    match_table_checker #(.DEPTH(DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .vendor_id(vendor_id), .device_id(device_id),
        .class_code(class_code), .subclass_code(subclass_code),
        .prog_interface(prog_interface), .subsystem_id(subsystem_id),
        .subsystem_vendor(subsystem_vendor), .handle_in(handle_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .handle_out(handle_out), .entry_index(entry_index),
        .pending(pending), .failures(failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic key_t make_key(logic [15:0] ven, logic [15:0] dev, logic [7:0] cls,
                                      logic [7:0] sub, logic [7:0] pif, logic [15:0] ssid,
                                      logic [15:0] ssven);
        key_t k;
        k.vendor_id        = ven;
        k.device_id        = dev;
        k.class_code       = cls;
        k.subclass_code    = sub;
        k.prog_interface   = pif;
        k.subsystem_id     = ssid;
        k.subsystem_vendor = ssven;
        return k;
    endfunction

    // Values lean toward all ones, zero and a tiny pool so that entries overlap.
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return WILD16;
            1: return 16'h0000;
            2, 3: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick8();
        case ($urandom_range(0, 7))
            0: return WILD8;
            1: return 8'h00;
            2, 3: return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic key_t random_pattern();
        key_t k;
        k = make_key(pick16(), pick16(), pick8(), pick8(), pick8(), pick16(), pick16());
        if ($urandom_range(0, 2) == 0) k.vendor_id = WILD16;
        if ($urandom_range(0, 2) == 0) k.device_id = WILD16;
        if ($urandom_range(0, 2) == 0) k.class_code = WILD8;
        if ($urandom_range(0, 2) == 0) k.subclass_code = WILD8;
        if ($urandom_range(0, 2) == 0) k.prog_interface = WILD8;
        if ($urandom_range(0, 2) == 0) k.subsystem_id = WILD16;
        if ($urandom_range(0, 2) == 0) k.subsystem_vendor = WILD16;
        return k;
    endfunction

    // Mostly a device that fits a stored pattern, sometimes one bit off,
    // sometimes unrelated noise.
    function automatic key_t random_probe();
        key_t k;
        key_t p;
        k = make_key(pick16(), pick16(), pick8(), pick8(), pick8(), pick16(), pick16());
        if (registered == 0 || $urandom_range(0, 4) == 0)
            return k;
        p = sent_patterns[$urandom_range(0, registered - 1)];
        if (p.vendor_id != WILD16) k.vendor_id = p.vendor_id;
        if (p.device_id != WILD16) k.device_id = p.device_id;
        if (p.class_code != WILD8) k.class_code = p.class_code;
        if (p.subclass_code != WILD8) k.subclass_code = p.subclass_code;
        if (p.prog_interface != WILD8) k.prog_interface = p.prog_interface;
        if (p.subsystem_id != WILD16) k.subsystem_id = p.subsystem_id;
        if (p.subsystem_vendor != WILD16) k.subsystem_vendor = p.subsystem_vendor;
        if ($urandom_range(0, 3) == 0)
            k = k ^ (88'd1 << $urandom_range(0, 87));
        return k;
    endfunction

    // Presents one item and returns at the edge of its transfer, leaving valid
    // high so that a following item can go out without a gap.
    task automatic transfer_item(input opcode_t op, input key_t k, input logic [15:0] h);
        if (drain_request)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            drain_request = 1'b0;
        end
        else if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= op;
        vendor_id        <= k.vendor_id;
        device_id        <= k.device_id;
        class_code       <= k.class_code;
        subclass_code    <= k.subclass_code;
        prog_interface   <= k.prog_interface;
        subsystem_id     <= k.subsystem_id;
        subsystem_vendor <= k.subsystem_vendor;
        handle_in        <= h;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (op == OP_REGISTER && registered < DEPTH)
        begin
            sent_patterns[registered] = k;
            registered++;
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (receiver_idles && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("pci_id_wildcard_match_table: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        key_t first_key;
        first_key = make_key(16'h8086, 16'h1234, 8'h02, 8'h00, 8'h00, 16'h0001, 16'h8086);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookups against the empty table.
        transfer_item(OP_LOOKUP, make_key(16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 16'h0, 16'h0),
                      16'h0000);
        transfer_item(OP_LOOKUP, '1, 16'hFFFF);
        transfer_item(OP_REGISTER, first_key, 16'hFFFF);
        transfer_item(OP_LOOKUP, first_key, 16'h0000);
        transfer_item(OP_LOOKUP, make_key(16'h8086, 16'h1235, 8'h02, 8'h00, 8'h00,
                                          16'h0001, 16'h8086), 16'h0000);
        // Vendor zero with every other field wild, and a zero handle.
        transfer_item(OP_REGISTER, make_key(16'h0000, WILD16, WILD8, WILD8, WILD8,
                                            WILD16, WILD16), 16'h0000);
        transfer_item(OP_LOOKUP, make_key(16'h0000, 16'h5555, 8'h0C, 8'h03, 8'h30,
                                          16'hABCD, 16'h1AF4), 16'h1111);
        // All ones on the device side is an ordinary value, not a wildcard.
        transfer_item(OP_LOOKUP, '1, 16'h0000);
        transfer_item(OP_REGISTER, make_key(WILD16, WILD16, 8'h01, 8'h06, 8'h01,
                                            WILD16, WILD16), 16'hA5A5);
        transfer_item(OP_LOOKUP, make_key(16'h1B4B, 16'h9230, 8'h01, 8'h06, 8'h01,
                                          16'h0000, 16'h0000), 16'h0000);
        transfer_item(OP_LOOKUP, make_key(16'h1B4B, 16'h9230, 8'h01, 8'h06, 8'h00,
                                          16'h0000, 16'h0000), 16'h0000);
        // A later duplicate must lose to the earlier entry.
        transfer_item(OP_REGISTER, first_key, 16'h1234);
        transfer_item(OP_LOOKUP, first_key, 16'hBEEF);
        transfer_item(OP_REGISTER, make_key(WILD16, WILD16, WILD8, WILD8, WILD8,
                                            WILD16, 16'hFFFE), 16'h5A5A);
        transfer_item(OP_LOOKUP, make_key(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                                          16'hFFFF, 16'hFFFE), 16'hFFFF);
        transfer_item(OP_LOOKUP, make_key(16'h8086, 16'h1234, 8'h02, 8'h00, 8'h00,
                                          16'h0001, 16'h8087), 16'h0000);

        // Registers keep coming after the table fills, so the full case recurs.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                sender_idles   = ($urandom_range(0, 2) != 0);
                receiver_idles = ($urandom_range(0, 2) != 0);
            end
            if (n >= RANDOM_ITEMS - 200)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            if (n % 400 == 200 && n < RANDOM_ITEMS - 200)
                drain_request = 1'b1;
            if ($urandom_range(0, 7) == 0)
                transfer_item(OP_REGISTER, random_pattern(), 16'($urandom));
            else
                transfer_item(OP_LOOKUP, random_probe(), 16'($urandom));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (failures == 0)
            $display("pci_id_wildcard_match_table: match");
        else
            $display("pci_id_wildcard_match_table: mismatch");
        $finish;
    end

endmodule
